>>> hdl/mi3_pkg.sv
// shared types and operand tables for the 3x3 matrix inverse
package mi3_pkg;

    typedef int unsigned idx_t;

    localparam int unsigned NUM_ELEM = 9;
    localparam int unsigned NUM_ROW  = 3;

    // adj[k] = e[PA_L[k]] * e[PA_R[k]] - e[PB_L[k]] * e[PB_R[k]]
    localparam idx_t PA_L [NUM_ELEM] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
    localparam idx_t PA_R [NUM_ELEM] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
    localparam idx_t PB_L [NUM_ELEM] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
    localparam idx_t PB_R [NUM_ELEM] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

    // first-row expansion uses adj 0, 3 and 6
    localparam idx_t DET_ADJ [NUM_ROW] = '{0, 3, 6};

    typedef struct packed {
        logic ce;
    } mi3_ctrl_t;

endpackage

>>> hdl/mi3_divider.sv
// pipelined restoring divider with saturation for one inverse element
module mi3_divider
    import mi3_pkg::*;
#(
    parameter int W  = 32,
    parameter int F  = 16,
    parameter int DW = 3 * W + 3
)
(
    input  logic           clk,
    input  mi3_ctrl_t      ctrl,
    input  logic           neg,
    input  logic [2*W-1:0] amag,
    input  logic [DW-1:0]  dmag,
    output logic [W-1:0]   quot,
    output logic           sat
);

    localparam int XA = DW + W;
    localparam int XB = 2 * W + 2 * F + 1;
    localparam int XW = (XA > XB) ? XA : XB;

    logic [XW-1:0] rem_reg  [W+1];
    logic [XW-1:0] rem_next [W+1];
    logic [XW-1:0] d_reg    [W+1];
    logic [W-1:0]  q_reg    [W+1];
    logic [W-1:0]  q_next   [W+1];
    logic          neg_reg  [W+1];
    logic          ovf_reg  [W+1];
    logic          ovf_next;
    logic [XW-1:0] num;
    logic [XW-1:0] trial    [W];
    logic          neg_eff;
    logic [W-1:0]  bound;
    logic          big;
    logic [W-1:0]  mag;
    logic [W-1:0]  quot_reg;
    logic [W-1:0]  quot_next;
    logic          sat_reg;

    always_comb
    begin
        num      = XW'(amag) << (2 * F);
        ovf_next = num >= (XW'(dmag) << W);
        rem_next[0] = num;
        q_next[0]   = '0;
        for (int k = 0; k < W; k++)
        begin
            trial[k]      = d_reg[k] << (W - 1 - k);
            rem_next[k+1] = rem_reg[k];
            q_next[k+1]   = q_reg[k];
            if (rem_reg[k] >= trial[k])
            begin
                rem_next[k+1]       = rem_reg[k] - trial[k];
                q_next[k+1][W-1-k]  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ce)
        begin
            rem_reg[0] <= rem_next[0];
            q_reg[0]   <= q_next[0];
            d_reg[0]   <= XW'(dmag);
            neg_reg[0] <= neg;
            ovf_reg[0] <= ovf_next;
            for (int k = 0; k < W; k++)
            begin
                rem_reg[k+1] <= rem_next[k+1];
                q_reg[k+1]   <= q_next[k+1];
                d_reg[k+1]   <= d_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
            quot_reg <= quot_next;
            sat_reg  <= big;
        end
    end

    always_comb
    begin
        neg_eff = neg_reg[W] && (ovf_reg[W] || (q_reg[W] != '0));
        bound   = neg_eff ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        big     = ovf_reg[W] || (q_reg[W] > bound);
        mag     = big ? bound : q_reg[W];
        quot_next = neg_eff ? (~mag + W'(1)) : mag;
    end

    assign quot = quot_reg;
    assign sat  = sat_reg;

endmodule

>>> hdl/matrix_inverse_3x3.sv
// top level: streaming 3x3 matrix inverse by adjugate over determinant
// One matrix is accepted per cycle unless a stall at the output holds the pipeline;
// there are five arithmetic stages and a W+2 stage restoring divider per element.
// A stall at the output freezes the whole pipeline while out_valid is high. A singular
// matrix gives zero fields with the singular flag; else clipped values raise the saturated flag.
module matrix_inverse_3x3
    import mi3_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [DATA_WIDTH-1:0] m00,
    input  logic signed [DATA_WIDTH-1:0] m01,
    input  logic signed [DATA_WIDTH-1:0] m02,
    input  logic signed [DATA_WIDTH-1:0] m10,
    input  logic signed [DATA_WIDTH-1:0] m11,
    input  logic signed [DATA_WIDTH-1:0] m12,
    input  logic signed [DATA_WIDTH-1:0] m20,
    input  logic signed [DATA_WIDTH-1:0] m21,
    input  logic signed [DATA_WIDTH-1:0] m22,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] inv00,
    output logic signed [DATA_WIDTH-1:0] inv01,
    output logic signed [DATA_WIDTH-1:0] inv02,
    output logic signed [DATA_WIDTH-1:0] inv10,
    output logic signed [DATA_WIDTH-1:0] inv11,
    output logic signed [DATA_WIDTH-1:0] inv12,
    output logic signed [DATA_WIDTH-1:0] inv20,
    output logic signed [DATA_WIDTH-1:0] inv21,
    output logic signed [DATA_WIDTH-1:0] inv22,
    output logic signed [DATA_WIDTH-1:0] determinant,
    output logic                         singular,
    output logic                         saturated
);

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int DW  = 3 * W + 3;
    localparam int L   = W + 2;
    localparam int LAT = 5 + L;

    mi3_ctrl_t ctrl;
    logic      ce;
    logic      v_reg [LAT];

    logic signed [W-1:0]   e [NUM_ELEM];

    logic signed [2*W-1:0] pa_reg   [NUM_ELEM];
    logic signed [2*W-1:0] pb_reg   [NUM_ELEM];
    logic signed [2*W-1:0] pa_next  [NUM_ELEM];
    logic signed [2*W-1:0] pb_next  [NUM_ELEM];
    logic signed [W-1:0]   er1_reg  [NUM_ROW];

    logic signed [2*W:0]   adj2_reg [NUM_ELEM];
    logic signed [W-1:0]   er2_reg  [NUM_ROW];

    logic signed [2*W:0]   plo_reg  [NUM_ROW];
    logic signed [2*W:0]   phi_reg  [NUM_ROW];
    logic signed [2*W:0]   plo_next [NUM_ROW];
    logic signed [2*W:0]   phi_next [NUM_ROW];
    logic signed [W:0]     lo_ext   [NUM_ROW];
    logic signed [W:0]     hi_part  [NUM_ROW];
    logic signed [2*W:0]   adj3_reg [NUM_ELEM];

    logic signed [DW-1:0]  det_reg;
    logic signed [DW-1:0]  det_next;
    logic signed [DW-1:0]  hi_ext   [NUM_ROW];
    logic signed [DW-1:0]  lo_wide  [NUM_ROW];
    logic signed [2*W:0]   adj4_reg [NUM_ELEM];

    logic                  aneg_reg [NUM_ELEM];
    logic [2*W-1:0]        amag_reg [NUM_ELEM];
    logic [2*W:0]          amag_full[NUM_ELEM];
    logic [DW-1:0]         dmag_reg;
    logic                  dneg_reg;
    logic [DW-1:0]         dmag_next;
    logic [DW-1:0]         tmag;
    logic                  tneg;
    logic [DW-1:0]         tbound;
    logic                  tbig;
    logic [W-1:0]          tval;
    logic [W-1:0]          detv_next;

    logic [W-1:0]          detv_reg [L+1];
    logic                  dsat_reg [L+1];
    logic                  sing_reg [L+1];

    logic [W-1:0]          quot     [NUM_ELEM];
    logic                  qsat     [NUM_ELEM];
    logic [W-1:0]          res      [NUM_ELEM];
    logic                  any_sat;

    assign ce       = !(v_reg[LAT-1] && out_stall);
    assign ctrl.ce  = ce;
    assign in_stall = !ce;

    assign e[0] = m00;
    assign e[1] = m01;
    assign e[2] = m02;
    assign e[3] = m10;
    assign e[4] = m11;
    assign e[5] = m12;
    assign e[6] = m20;
    assign e[7] = m21;
    assign e[8] = m22;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (ce)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k < LAT; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // cofactor products, partial determinant products, determinant sum, magnitudes, clipped determinant
    always_comb
    begin
        for (int k = 0; k < NUM_ELEM; k++)
        begin
            pa_next[k] = e[PA_L[k]] * e[PA_R[k]];
            pb_next[k] = e[PB_L[k]] * e[PB_R[k]];
        end
        for (int r = 0; r < NUM_ROW; r++)
        begin
            lo_ext[r]   = $signed({1'b0, adj2_reg[DET_ADJ[r]][W-1:0]});
            hi_part[r]  = adj2_reg[DET_ADJ[r]][2*W:W];
            plo_next[r] = er2_reg[r] * lo_ext[r];
            phi_next[r] = er2_reg[r] * hi_part[r];
        end
        det_next = '0;
        for (int r = 0; r < NUM_ROW; r++)
        begin
            hi_ext[r]  = phi_reg[r];
            lo_wide[r] = plo_reg[r];
            det_next   = det_next + (hi_ext[r] <<< W) + lo_wide[r];
        end
        for (int k = 0; k < NUM_ELEM; k++)
        begin
            amag_full[k] = adj4_reg[k][2*W] ? (~adj4_reg[k] + 1'b1) : adj4_reg[k];
        end
        dmag_next = det_reg[DW-1] ? (~det_reg + 1'b1) : det_reg;
        tmag      = dmag_next >> (2 * F);
        tneg      = det_reg[DW-1] && (tmag != '0);
        tbound    = tneg ? (DW'(1) << (W - 1)) : ((DW'(1) << (W - 1)) - DW'(1));
        tbig      = tmag > tbound;
        tval      = tbig ? tbound[W-1:0] : tmag[W-1:0];
        detv_next = tneg ? (~tval + W'(1)) : tval;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int k = 0; k < NUM_ELEM; k++)
            begin
                pa_reg[k]   <= pa_next[k];
                pb_reg[k]   <= pb_next[k];
                adj2_reg[k] <= (2*W+1)'(pa_reg[k]) - (2*W+1)'(pb_reg[k]);
                adj3_reg[k] <= adj2_reg[k];
                adj4_reg[k] <= adj3_reg[k];
                aneg_reg[k] <= adj4_reg[k][2*W];
                amag_reg[k] <= amag_full[k][2*W-1:0];
            end
            for (int r = 0; r < NUM_ROW; r++)
            begin
                er1_reg[r] <= e[r];
                er2_reg[r] <= er1_reg[r];
                plo_reg[r] <= plo_next[r];
                phi_reg[r] <= phi_next[r];
            end
            det_reg     <= det_next;
            dmag_reg    <= dmag_next;
            dneg_reg    <= det_reg[DW-1];
            detv_reg[0] <= detv_next;
            dsat_reg[0] <= tbig;
            sing_reg[0] <= det_reg == '0;
            for (int k = 1; k <= L; k++)
            begin
                detv_reg[k] <= detv_reg[k-1];
                dsat_reg[k] <= dsat_reg[k-1];
                sing_reg[k] <= sing_reg[k-1];
            end
        end
    end

    for (genvar g = 0; g < NUM_ELEM; g++)
    begin : g_div
        mi3_divider #(
            .W  (W),
            .F  (F),
            .DW (DW)
        ) u_div (
            .clk  (clk),
            .ctrl (ctrl),
            .neg  (aneg_reg[g] ^ dneg_reg),
            .amag (amag_reg[g]),
            .dmag (dmag_reg),
            .quot (quot[g]),
            .sat  (qsat[g])
        );
    end

    always_comb
    begin
        any_sat = dsat_reg[L];
        for (int k = 0; k < NUM_ELEM; k++)
        begin
            res[k]  = sing_reg[L] ? '0 : quot[k];
            any_sat = any_sat || qsat[k];
        end
    end

    assign out_valid   = v_reg[LAT-1];
    assign inv00       = res[0];
    assign inv01       = res[1];
    assign inv02       = res[2];
    assign inv10       = res[3];
    assign inv11       = res[4];
    assign inv12       = res[5];
    assign inv20       = res[6];
    assign inv21       = res[7];
    assign inv22       = res[8];
    assign determinant = sing_reg[L] ? '0 : detv_reg[L];
    assign singular    = sing_reg[L];
    assign saturated   = sing_reg[L] ? 1'b0 : any_sat;

    a_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v_reg[0])
        else $error("accepted beat not captured");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(determinant) && $stable(inv11)))
        else $error("pipeline moved during stall");

    a_singular: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && singular) |-> (determinant == '0 && !saturated && inv00 == '0))
        else $error("singular beat with nonzero fields");

endmodule
